// ===== design/r2h_pkg.sv =====
// ---------------------------------------------------------------------------
// r2h_pkg: shared types and constants for the rgb to hsi pixel unit
// data word carried along the cell chain, cordic angle table, fixed widths
// ---------------------------------------------------------------------------
package r2h_pkg;

    localparam int XW        = 29;  // cordic x/y width, signed
    localparam int AW        = 27;  // angle width, degrees q16, signed
    localparam int RW        = 18;  // division remainder width
    localparam int DW        = 10;  // divisor (channel sum) width
    localparam int QW        = 8;   // quotient width
    localparam int NSTEPS    = 16;  // cordic steps, one per cell
    localparam int SQ3_Q16   = 113512;
    localparam int ANG_180   = 11796480;
    localparam int ANG_360   = 23592960;
    localparam int HALF_DEG  = 32768;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] ang;
        logic [RW-1:0]        rem;
        logic [DW-1:0]        den;
        logic [QW-1:0]        quo;
        logic                 gray;
        logic                 sat_zero;
        logic [7:0]           inten;
    } t_cell_data;

    function automatic logic signed [AW-1:0] atan_q16(input logic [3:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            4'd0:    v = AW'(2949120);
            4'd1:    v = AW'(1740967);
            4'd2:    v = AW'(919879);
            4'd3:    v = AW'(466945);
            4'd4:    v = AW'(234379);
            4'd5:    v = AW'(117306);
            4'd6:    v = AW'(58666);
            4'd7:    v = AW'(29335);
            4'd8:    v = AW'(14668);
            4'd9:    v = AW'(7334);
            4'd10:   v = AW'(3667);
            4'd11:   v = AW'(1833);
            4'd12:   v = AW'(917);
            4'd13:   v = AW'(458);
            4'd14:   v = AW'(229);
            4'd15:   v = AW'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/r2h_cell.sv =====
// ---------------------------------------------------------------------------
// r2h_cell: one cell of the conversion chain
// one cordic vectoring step, plus one restoring division bit in early cells
// ---------------------------------------------------------------------------
module r2h_cell
    import r2h_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cell_data i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_data o_data
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic       w_en;
    logic signed [XW-1:0] w_dx, w_dy;
    logic [RW-1:0] w_dsh;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        w_dx   = i_data.y >>> STEP;
        w_dy   = i_data.x >>> STEP;
        if (i_data.y > 0) begin
            n_data.x   = i_data.x + w_dx;
            n_data.y   = i_data.y - w_dy;
            n_data.ang = i_data.ang + atan_q16(4'(STEP));
        end else begin
            n_data.x   = i_data.x - w_dx;
            n_data.y   = i_data.y + w_dy;
            n_data.ang = i_data.ang - atan_q16(4'(STEP));
        end
        // quotient bit (QW-1-STEP) in the first QW cells
        w_dsh = '0;
        if (STEP < QW) begin
            w_dsh = RW'(i_data.den) << (QW - 1 - STEP);
            if (i_data.rem >= w_dsh) begin
                n_data.rem = i_data.rem - w_dsh;
                n_data.quo = i_data.quo | QW'(QW'(1) << (QW - 1 - STEP));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/rgb_to_hsi_pixel_unit.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsi_pixel_unit: rgb pixel to hue, saturation, intensity
// ---------------------------------------------------------------------------
// usage
//   input stream s_axis: one item is one rgb pixel of three 8-bit channels, taken when
//   s_axis_tvalid and s_axis_tready are both high
//   output stream m_axis: one item per pixel, in order, hue 0..359 degrees,
//   saturation 0..255, intensity floor of the channel mean
//   from accept to m_axis_tvalid an item passes the 16 chain cells and then
//   the output register; throughput one pixel per cycle while m_axis_tready is high
//   the rate is set by the cell chain: each cell does one cordic step and,
//   in the first eight cells, one bit of the saturation divide
//   every cell holds its own item and advances whenever its successor has
//   room, so bubbles collapse and input is taken while a result waits
//   reset clears all valid bits; no item is in flight afterwards
//   when m_axis_tready stays low the chain fills and s_axis_tready drops
//   only once every cell holds an item
// ---------------------------------------------------------------------------
module rgb_to_hsi_pixel_unit
    import r2h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hue[8:0], saturation[16:9], intensity[24:17]
);

    // input prep
    logic [7:0] w_r, w_g, w_b, w_mn;
    logic signed [10:0] w_cx;
    logic signed [9:0]  w_cy;
    logic [10:0] w_cxa;
    logic signed [XW-1:0] w_cyn;
    logic [DW-1:0] w_sum, w_diff;
    logic [19:0]   w_prod3;
    t_cell_data    w_in;

    assign w_r = s_axis_tdata[7:0];
    assign w_g = s_axis_tdata[15:8];
    assign w_b = s_axis_tdata[23:16];

    always_comb begin
        w_cx    = $signed({2'b00, w_r, 1'b0}) - $signed({3'b000, w_g})
                  - $signed({3'b000, w_b});
        w_cy    = $signed({2'b00, w_g}) - $signed({2'b00, w_b});
        w_sum   = DW'(w_r) + DW'(w_g) + DW'(w_b);
        w_mn    = (w_r < w_g) ? w_r : w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_prod3 = 20'(w_sum) * 20'd683;        // floor(sum/3) for sum < 1536
        w_diff  = w_sum - DW'(3 * w_mn);
        w_in          = '0;
        w_in.inten    = w_prod3[18:11];
        w_in.sat_zero = (w_prod3[18:11] == 8'd0);
        w_in.gray     = (w_cx == 0) && (w_cy == 0);
        w_in.den      = w_sum;
        w_in.rem      = {w_diff, 8'b0} - RW'(w_diff);   // 255 * diff
        // left half plane: rotate by 180 degrees first
        if (w_cx < 0) begin
            w_cxa  = 11'(-w_cx);
            w_cyn  = -XW'(w_cy);
            w_in.ang = AW'(ANG_180);
        end else begin
            w_cxa  = w_cx;
            w_cyn  = XW'(w_cy);
            w_in.ang = '0;
        end
        w_in.x = $signed({XW'(w_cxa)} << 16);
        w_in.y = XW'(w_cyn * $signed(XW'(SQ3_Q16)));
    end

    // cell chain
    logic       w_vld [NSTEPS+1];
    logic       w_rdy [NSTEPS+1];
    t_cell_data w_dat [NSTEPS+1];

    assign w_vld[0]      = s_axis_tvalid;
    assign w_dat[0]      = w_in;
    assign s_axis_tready = w_rdy[0];

    for (genvar k = 0; k < NSTEPS; k++) begin : g_cell
        r2h_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[k]),
            .o_ready (w_rdy[k]),
            .i_data  (w_dat[k]),
            .o_valid (w_vld[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_data  (w_dat[k+1])
        );
    end

    // output stage: angle wrap, rounding, gray and zero-intensity overrides
    logic signed [AW-1:0] w_ang;
    logic [AW-1:0] w_rnd;
    logic [8:0]    w_hue;
    logic [7:0]    w_sat;
    logic          r_ovalid;
    logic [31:0]   r_odata;
    logic          w_oen;

    always_comb begin
        w_ang = w_dat[NSTEPS].ang;
        if (w_ang < 0) w_ang = w_ang + AW'(ANG_360);
        w_rnd = AW'(w_ang) + AW'(HALF_DEG);
        w_hue = w_rnd[24:16];
        if (w_hue >= 9'd360) w_hue = w_hue - 9'd360;
        if (w_dat[NSTEPS].gray) w_hue = '0;
        w_sat = w_dat[NSTEPS].sat_zero ? 8'd0 : w_dat[NSTEPS].quo;
    end

    assign w_oen          = !r_ovalid || m_axis_tready;
    assign w_rdy[NSTEPS]  = w_oen;
    assign m_axis_tvalid  = r_ovalid;
    assign m_axis_tdata   = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oen) begin
            r_ovalid <= w_vld[NSTEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oen && w_vld[NSTEPS]) begin
            r_odata <= {7'b0, w_dat[NSTEPS].inten, w_sat, w_hue};
        end
    end

    // checks
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:0] < 9'd360))
        else $error("hue out of range");

    a_sat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[24:17] == 8'd0) |-> (m_axis_tdata[16:9] == 8'd0))
        else $error("saturation nonzero at zero intensity");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (s_axis_tready && !m_axis_tvalid))
        else $error("chain not empty after reset");

endmodule
